@@ rtl/ddm_pkg.sv @@
// Package for the decimal digit multiplier: sizes, command codes, sequencer
// states and the digit multiply-accumulate operand bundle.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package ddm_pkg;

	// Capacity of each operand in decimal digits
	localparam int MAX_DIGITS  = 16;
	localparam int PROD_DIGITS = 2 * MAX_DIGITS;

	localparam int DIGIT_W = 4;
	localparam int LEN_W   = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int PROD_W  = $clog2(PROD_DIGITS);

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);
	localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_DIGITS);
	localparam logic [PROD_W-1:0]  PROD_TOP  = PROD_W'(PROD_DIGITS - 1);

	// Operand select carried by each input item
	localparam logic CMD_FIRST  = 1'b0;
	localparam logic CMD_SECOND = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_CARRY = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// Operands of one digit multiply-accumulate step: p + a * b + c
	typedef struct packed {
		logic [DIGIT_W-1:0] a;
		logic [DIGIT_W-1:0] b;
		logic [DIGIT_W-1:0] p;
		logic [DIGIT_W-1:0] c;
	} mac_in_t;

endpackage

@@ rtl/ddm_in_if.sv @@
// Input channel of the decimal digit multiplier: one operand digit per item.
// Depends on ddm_pkg for the digit width.
interface ddm_in_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [ddm_pkg::DIGIT_W-1:0] digit;
	logic                        last_digit;

	modport source (output valid, output cmd, output digit, output last_digit, input ready);
	modport sink (input valid, input cmd, input digit, input last_digit, output ready);
endinterface

@@ rtl/ddm_out_if.sv @@
// Output channel of the decimal digit multiplier: one product digit per item.
// Depends on ddm_pkg for the digit width.
interface ddm_out_if;
	logic                        valid;
	logic                        ready;
	logic [ddm_pkg::DIGIT_W-1:0] product_digit;
	logic                        last_product;
	logic                        overflow;

	modport source (output valid, output product_digit, output last_product,
		output overflow, input ready);
	modport sink (input valid, input product_digit, input last_product,
		input overflow, output ready);
endinterface

@@ rtl/ddm_mac.sv @@
// Decimal multiply-accumulate step: t = p + a * b + c, split into t mod 10
// and t div 10. Purely combinational; depends on ddm_pkg.
module ddm_mac (
	input  ddm_pkg::mac_in_t              mi,
	output logic [ddm_pkg::DIGIT_W-1:0]   sum_digit,
	output logic [ddm_pkg::DIGIT_W-1:0]   carry
);
	logic [6:0]  t;
	logic [14:0] qm;
	logic [3:0]  q;
	logic [6:0]  r;

	// Sum stays at or below 99 for decimal digits
	assign t = 7'(mi.p) + 7'(mi.a) * 7'(mi.b) + 7'(mi.c);

	// Divide by ten through the reciprocal 205 / 2048, exact below 1029
	assign qm = 15'(t) * 15'd205;
	assign q  = qm[14:11];
	assign r  = t - 7'(q) * 7'd10;

	assign sum_digit = r[ddm_pkg::DIGIT_W-1:0];
	assign carry     = q;
endmodule

@@ rtl/decimal_digit_multiplier_core.sv @@
// Top level of the decimal digit multiplier: operand digit store, long
// multiplication sequencer over one shared ddm_mac unit, product digit output.
// Depends on ddm_pkg, ddm_in_if, ddm_out_if and ddm_mac.
//
//   port     dir   handshake     payload
//   operand  sink  valid/ready   cmd, digit, last_digit
//   product  src   valid/ready   product_digit, last_product, overflow
//
// Operand digits are taken one per cycle while the block is idle. The last
// digit of the second operand starts the multiply: one ddm_mac step per digit
// pair plus one carry step per first-operand digit, then a scan from the top
// product digit down to the first nonzero one or to digit zero, then one
// product digit per cycle while the sink takes them.
// operand.ready is low from that last digit until the final product digit
// leaves. Reset clears all control state; no clearing pass is needed.
module decimal_digit_multiplier_core (
	input  logic            clk,
	input  logic            arst_n,
	ddm_in_if.sink          operand,
	ddm_out_if.source       product
);
	localparam int MAXD  = ddm_pkg::MAX_DIGITS;
	localparam int PRODD = ddm_pkg::PROD_DIGITS;
	localparam int DW    = ddm_pkg::DIGIT_W;
	localparam int LW    = ddm_pkg::LEN_W;
	localparam int AW    = ddm_pkg::ADDR_W;
	localparam int PW    = ddm_pkg::PROD_W;

	ddm_pkg::state_t state_q;

	logic [DW-1:0] first_q  [MAXD];
	logic [DW-1:0] second_q [MAXD];
	logic [DW-1:0] prod_q   [PRODD];

	logic [LW-1:0] first_len_q;
	logic [LW-1:0] second_len_q;
	logic          first_closed_q;
	logic          ovf_q;
	logic [LW-1:0] i_q;
	logic [LW-1:0] j_q;
	logic [DW-1:0] carry_q;
	logic [PW-1:0] k_q;

	logic          in_acc;
	logic          out_acc;
	logic [DW-1:0] d_sat;
	logic [LW-1:0] a_pos;
	logic [LW-1:0] b_pos;
	logic [LW:0]   p_sum;
	logic [LW:0]   c_sum;
	logic [PW-1:0] p_idx;
	logic [PW-1:0] c_idx;
	logic [LW-1:0] i_next;
	logic [LW-1:0] j_next;

	ddm_pkg::mac_in_t mi;
	logic [DW-1:0]    mac_digit;
	logic [DW-1:0]    mac_carry;

	assign in_acc  = operand.valid && operand.ready;
	assign out_acc = product.valid && product.ready;

	// Saturate digit codes above nine
	assign d_sat = (operand.digit > ddm_pkg::DIGIT_MAX) ? ddm_pkg::DIGIT_MAX : operand.digit;

	// Address the operand digits from the least significant end
	assign a_pos  = first_len_q - LW'(1) - i_q;
	assign b_pos  = second_len_q - LW'(1) - j_q;
	assign p_sum  = (LW+1)'(i_q) + (LW+1)'(j_q);
	assign c_sum  = (LW+1)'(i_q) + (LW+1)'(second_len_q);
	assign p_idx  = p_sum[PW-1:0];
	assign c_idx  = c_sum[PW-1:0];
	assign i_next = i_q + LW'(1);
	assign j_next = j_q + LW'(1);

	assign mi.a = first_q[a_pos[AW-1:0]];
	assign mi.b = second_q[b_pos[AW-1:0]];
	assign mi.p = prod_q[p_idx];
	assign mi.c = carry_q;

	ddm_mac u_mac (
		.mi        (mi),
		.sum_digit (mac_digit),
		.carry     (mac_carry)
	);

	// Handshake and output payload
	assign operand.ready         = (state_q == ddm_pkg::ST_IDLE);
	assign product.valid         = (state_q == ddm_pkg::ST_OUT);
	assign product.product_digit = prod_q[k_q];
	assign product.last_product  = (k_q == '0);
	assign product.overflow      = ovf_q;

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ddm_pkg::ST_IDLE;
			first_len_q    <= '0;
			second_len_q   <= '0;
			first_closed_q <= 1'b0;
			ovf_q          <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			carry_q        <= '0;
			k_q            <= '0;
		end else begin
			case (state_q)
				ddm_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (operand.cmd == ddm_pkg::CMD_FIRST) begin
							if (first_closed_q) begin
								first_len_q    <= LW'(1);
								first_closed_q <= operand.last_digit;
							end else begin
								if (first_len_q < ddm_pkg::LEN_MAX) begin
									first_len_q <= first_len_q + LW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
								if (operand.last_digit) begin
									first_closed_q <= 1'b1;
								end
							end
						end else begin
							if (second_len_q < ddm_pkg::LEN_MAX) begin
								second_len_q <= second_len_q + LW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
							if (operand.last_digit) begin
								i_q     <= '0;
								j_q     <= '0;
								carry_q <= '0;
								k_q     <= ddm_pkg::PROD_TOP;
								state_q <= (first_len_q == '0) ? ddm_pkg::ST_SCAN
									: ddm_pkg::ST_MUL;
							end
						end
					end
				end
				ddm_pkg::ST_MUL: begin
					carry_q <= mac_carry;
					if (j_next == second_len_q) begin
						state_q <= ddm_pkg::ST_CARRY;
					end else begin
						j_q <= j_next;
					end
				end
				ddm_pkg::ST_CARRY: begin
					carry_q <= '0;
					j_q     <= '0;
					i_q     <= i_next;
					state_q <= (i_next == first_len_q) ? ddm_pkg::ST_SCAN : ddm_pkg::ST_MUL;
				end
				ddm_pkg::ST_SCAN: begin
					// Stop at the top nonzero digit, or at digit zero
					if (prod_q[k_q] != '0 || k_q == '0) begin
						state_q <= ddm_pkg::ST_OUT;
					end else begin
						k_q <= k_q - PW'(1);
					end
				end
				ddm_pkg::ST_OUT: begin
					if (out_acc) begin
						if (k_q == '0) begin
							first_len_q    <= '0;
							second_len_q   <= '0;
							first_closed_q <= 1'b0;
							ovf_q          <= 1'b0;
							state_q        <= ddm_pkg::ST_IDLE;
						end else begin
							k_q <= k_q - PW'(1);
						end
					end
				end
				default: begin
					state_q <= ddm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Operand digit stores
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (operand.cmd == ddm_pkg::CMD_FIRST) begin
				if (first_closed_q) begin
					first_q[0] <= d_sat;
				end else if (first_len_q < ddm_pkg::LEN_MAX) begin
					first_q[first_len_q[AW-1:0]] <= d_sat;
				end
			end else if (second_len_q < ddm_pkg::LEN_MAX) begin
				second_q[second_len_q[AW-1:0]] <= d_sat;
			end
		end
	end

	// Product digits: clear at multiply start, accumulate, place row carries
	always_ff @(posedge clk) begin
		if (in_acc && operand.cmd == ddm_pkg::CMD_SECOND && operand.last_digit) begin
			for (int n = 0; n < PRODD; n++) begin
				prod_q[n] <= '0;
			end
		end else if (state_q == ddm_pkg::ST_MUL) begin
			prod_q[p_idx] <= mac_digit;
		end else if (state_q == ddm_pkg::ST_CARRY) begin
			prod_q[c_idx] <= carry_q;
		end
	end

	// Never take operand digits while product digits are offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(operand.ready && product.valid))
		else $error("operand ready while product valid");

	// The closing digit of the second operand stops intake
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && operand.cmd == ddm_pkg::CMD_SECOND && operand.last_digit |=> !operand.ready)
		else $error("intake still open after multiply start");

	// The least significant product digit returns the block to intake
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && product.last_product |=> operand.ready && !product.valid)
		else $error("block not idle after last product digit");

	// The running carry is a single decimal digit
	a_carry_range: assert property (@(posedge clk) disable iff (!arst_n)
		carry_q <= ddm_pkg::DIGIT_MAX)
		else $error("carry out of decimal range");

endmodule
